@@ sv/bank_switch_mapper_with_scanline_irq_defines.svh @@
// Assertion helpers shared by the mapper RTL.
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MMC3_ASSERT_IMP(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MMC3_ASSERT_NXT(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ sv/mmc3_pkg.sv @@
package mmc3_pkg;

   localparam int PRG_ADDR_BITS = 21;
   localparam int CHR_ADDR_BITS = 18;
   localparam int MEM_ADDR_W    = 21;
   localparam int NUM_BANKS     = 8;
   localparam int SIZE_LOG2_W   = 5;
   localparam int CFG_INDEX_W   = 2;

   typedef enum logic [1:0] {
      OP_CPU_READ  = 2'd0,
      OP_CPU_WRITE = 2'd1,
      OP_PPU_READ  = 2'd2,
      OP_PPU_WRITE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      TGT_NONE     = 3'd0,
      TGT_PRG_ROM  = 3'd1,
      TGT_WORK_RAM = 3'd2,
      TGT_CHR_ROM  = 3'd3,
      TGT_CHR_RAM  = 3'd4,
      TGT_REGISTER = 3'd5
   } tgt_type;

   // {A14, A13, A0} of a CPU write at 0x8000-0xFFFF
   typedef enum logic [2:0] {
      REG_BANK_SELECT = 3'b000,
      REG_BANK_DATA   = 3'b001,
      REG_MIRROR      = 3'b010,
      REG_RAM_PROTECT = 3'b011,
      REG_IRQ_LATCH   = 3'b100,
      REG_IRQ_RELOAD  = 3'b101,
      REG_IRQ_DISABLE = 3'b110,
      REG_IRQ_ENABLE  = 3'b111
   } reg_sel_type;

   typedef enum logic [CFG_INDEX_W-1:0] {
      CFG_PRG_SIZE  = 2'd0,
      CFG_CHR_SIZE  = 2'd1,
      CFG_CHR_RAM   = 2'd2,
      CFG_RAM_ALWAYS = 2'd3
   } cfg_index_type;

   typedef logic [NUM_BANKS-1:0][7:0] bank_file_type;

   typedef struct packed {
      logic                   prg_swap;
      logic                   chr_invert;
      logic                   ram_read_ok;
      logic                   ram_write_ok;
      logic [SIZE_LOG2_W-1:0] prg_size_log2;
      logic [SIZE_LOG2_W-1:0] chr_size_log2;
      logic                   chr_is_ram;
      logic                   ram_always_on;
   } map_ctl_type;

   typedef struct packed {
      logic       ppu_access;
      logic       a12;
      logic       set_latch;
      logic [7:0] latch_val;
      logic       set_reload;
      logic       irq_disable;
      logic       irq_arm;
   } irq_ctl_type;

endpackage

@@ sv/mmc3_irq.sv @@
module mmc3_irq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  mmc3_pkg::irq_ctl_type ctl,
   output logic                 irq_next
);
   import mmc3_pkg::*;

   logic [7:0] latch_ff, latch_in;
   logic [7:0] count_ff, count_in;
   logic       reload_ff, reload_in;
   logic       enabled_ff, enabled_in;
   logic       last_a12_ff, last_a12_in;
   logic       pending_ff, pending_in;
   logic       rise;
   logic [7:0] count_clk;

   assign rise      = ctl.ppu_access && ctl.a12 && !last_a12_ff;
   assign count_clk = ((count_ff == 8'd0) || reload_ff) ? latch_ff : count_ff - 8'd1;

   always_comb begin
      latch_in    = ctl.set_latch ? ctl.latch_val : latch_ff;
      count_in    = rise ? count_clk : count_ff;
      reload_in   = ctl.set_reload ? 1'b1 : (rise ? 1'b0 : reload_ff);
      last_a12_in = ctl.ppu_access ? ctl.a12 : last_a12_ff;
      priority if (ctl.irq_disable) begin
         enabled_in = 1'b0;
      end else if (ctl.irq_arm) begin
         enabled_in = 1'b1;
      end else begin
         enabled_in = enabled_ff;
      end
      priority if (ctl.irq_disable) begin
         pending_in = 1'b0;
      end else if (rise && (count_clk == 8'd0) && enabled_ff) begin
         pending_in = 1'b1;
      end else begin
         pending_in = pending_ff;
      end
   end

   assign irq_next = pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff    <= 8'd0;
         count_ff    <= 8'd0;
         reload_ff   <= 1'b0;
         enabled_ff  <= 1'b0;
         last_a12_ff <= 1'b1;
         pending_ff  <= 1'b0;
      end else if (fire) begin
         latch_ff    <= latch_in;
         count_ff    <= count_in;
         reload_ff   <= reload_in;
         enabled_ff  <= enabled_in;
         last_a12_ff <= last_a12_in;
         pending_ff  <= pending_in;
      end
   end

endmodule

@@ sv/mmc3_map.sv @@
module mmc3_map (
   input  mmc3_pkg::op_type                     op,
   input  logic [15:0]                          address,
   input  mmc3_pkg::bank_file_type              banks,
   input  mmc3_pkg::map_ctl_type                ctl,
   output mmc3_pkg::tgt_type                    target,
   output logic [mmc3_pkg::MEM_ADDR_W-1:0]      mem_addr,
   output logic                                 write_strobe
);
   import mmc3_pkg::*;

   logic [SIZE_LOG2_W-1:0]   prg_log, chr_log;
   logic [PRG_ADDR_BITS:0]   prg_mask_wide;
   logic [PRG_ADDR_BITS-1:0] prg_mask, prg_base, prg_xlat;
   logic [CHR_ADDR_BITS:0]   chr_mask_wide;
   logic [CHR_ADDR_BITS-1:0] chr_mask, chr_base, chr_xlat;
   logic [15:0]              a_sw;
   logic [12:0]              pa;
   logic                     wram_hit;

   // Size clamps: PRG 16K..2M, CHR 1K..256K
   always_comb begin
      priority if (ctl.prg_size_log2 < SIZE_LOG2_W'(14)) begin
         prg_log = SIZE_LOG2_W'(14);
      end else if (ctl.prg_size_log2 > SIZE_LOG2_W'(PRG_ADDR_BITS)) begin
         prg_log = SIZE_LOG2_W'(PRG_ADDR_BITS);
      end else begin
         prg_log = ctl.prg_size_log2;
      end
      priority if (ctl.chr_size_log2 < SIZE_LOG2_W'(10)) begin
         chr_log = SIZE_LOG2_W'(10);
      end else if (ctl.chr_size_log2 > SIZE_LOG2_W'(CHR_ADDR_BITS)) begin
         chr_log = SIZE_LOG2_W'(CHR_ADDR_BITS);
      end else begin
         chr_log = ctl.chr_size_log2;
      end
   end

   assign prg_mask_wide = ({{PRG_ADDR_BITS{1'b0}}, 1'b1} << prg_log) - 1'b1;
   assign prg_mask      = prg_mask_wide[PRG_ADDR_BITS-1:0];
   assign chr_mask_wide = ({{CHR_ADDR_BITS{1'b0}}, 1'b1} << chr_log) - 1'b1;
   assign chr_mask      = chr_mask_wide[CHR_ADDR_BITS-1:0];

   // PRG: swap mode exchanges the 0x8000 and 0xC000 windows
   always_comb begin
      a_sw = address;
      if (ctl.prg_swap && !address[13]) begin
         a_sw[14] = ~address[14];
      end
      unique case (a_sw[14:13])
         2'b00:   prg_base = {banks[6], 13'd0};
         2'b01:   prg_base = {banks[7], 13'd0};
         2'b10:   prg_base = prg_mask & ~PRG_ADDR_BITS'(16'h3fff);
         default: prg_base = prg_mask & ~PRG_ADDR_BITS'(16'h1fff);
      endcase
      prg_xlat = (PRG_ADDR_BITS'(a_sw[12:0]) | prg_base) & prg_mask;
   end

   // CHR: two 2K windows and four 1K windows, halves swapped by invert mode
   always_comb begin
      pa = address[12:0];
      pa[12] = address[12] ^ ctl.chr_invert;
      unique case (pa[12:10])
         3'b000, 3'b001: chr_base = {banks[0][7:1], 1'b0, 10'd0};
         3'b010, 3'b011: chr_base = {banks[1][7:1], 1'b0, 10'd0};
         3'b100:         chr_base = {banks[2], 10'd0};
         3'b101:         chr_base = {banks[3], 10'd0};
         3'b110:         chr_base = {banks[4], 10'd0};
         default:        chr_base = {banks[5], 10'd0};
      endcase
      chr_xlat = (pa[12] ? CHR_ADDR_BITS'(pa[9:0]) : CHR_ADDR_BITS'(pa[10:0])) | chr_base;
   end

   assign wram_hit = (address[15:13] == 3'b011);

   always_comb begin
      target       = TGT_NONE;
      mem_addr     = '0;
      write_strobe = 1'b0;
      unique case (op)
         OP_CPU_READ: begin
            if (address[15]) begin
               target   = TGT_PRG_ROM;
               mem_addr = prg_xlat;
            end else if (wram_hit && (ctl.ram_always_on || ctl.ram_read_ok)) begin
               target   = TGT_WORK_RAM;
               mem_addr = MEM_ADDR_W'(address[12:0]);
            end
         end
         OP_CPU_WRITE: begin
            if (address[15]) begin
               target   = TGT_REGISTER;
               mem_addr = MEM_ADDR_W'({address[15:13], 12'd0, address[0]});
            end else if (wram_hit && (ctl.ram_always_on || ctl.ram_write_ok)) begin
               target       = TGT_WORK_RAM;
               mem_addr     = MEM_ADDR_W'(address[12:0]);
               write_strobe = 1'b1;
            end
         end
         OP_PPU_READ: begin
            target   = ctl.chr_is_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
            mem_addr = MEM_ADDR_W'(chr_xlat & chr_mask);
         end
         OP_PPU_WRITE: begin
            if (ctl.chr_is_ram) begin
               target       = TGT_CHR_RAM;
               mem_addr     = MEM_ADDR_W'(chr_xlat & chr_mask & CHR_ADDR_BITS'(16'h1fff));
               write_strobe = 1'b1;
            end
         end
         default: begin
            target = TGT_NONE;
         end
      endcase
   end

endmodule

@@ sv/bank_switch_mapper_with_scanline_irq.sv @@
// Bank-switching cartridge mapper with scanline interrupt counter. Each request on req_ is one
// CPU or PPU bus access (kind in req_tuser); the response on rsp_ names the memory it reaches,
// the physical byte address within it, a write strobe, and the interrupt line and mirroring bit
// as they stand after that access. CPU writes at 0x8000-0xFFFF program the bank, mode, RAM
// protect and IRQ registers; CPU reads there map through two switchable and two fixed 8K PRG
// banks; 0x6000-0x7FFF reaches work RAM when enabled; PPU pattern accesses map through 2K/1K
// CHR banks and rising edges of PPU A12 clock the counter. One request is taken every cycle
// while the response side is not stalled; each request passes the input register, then the
// result register, with the single translate stage between them. A stalled response holds the
// pipe; csr_ writes are taken at once and must only be issued while no request is in flight.
module bank_switch_mapper_with_scanline_irq (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // address[15:0], wdata[23:16]
   input  logic [1:0]  req_tuser,   // op[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // mem_addr[20:0], write_strobe[21], irq_out[22],
                                    // mirror_horizontal[23]
   output logic [2:0]  rsp_tuser,   // target[2:0]
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);
   import mmc3_pkg::*;
`include "bank_switch_mapper_with_scanline_irq_defines.svh"

   // ---- input register ----
   logic        in_valid_ff, in_valid_in;
   op_type      in_op_ff;
   logic [15:0] in_addr_ff;
   logic [7:0]  in_wdata_ff;
   logic        advance, fire, req_fire;

   // ---- mapper state ----
   logic [2:0]    bank_idx_ff, bank_idx_in;
   bank_file_type banks_ff, banks_in;
   logic          prg_swap_ff, prg_swap_in;
   logic          chr_inv_ff, chr_inv_in;
   logic          mirror_ff, mirror_in;
   logic          ram_rd_ff, ram_rd_in;
   logic          ram_wr_ff, ram_wr_in;

   // ---- configuration ----
   logic [SIZE_LOG2_W-1:0] cfg_prg_log_ff, cfg_chr_log_ff;
   logic                   cfg_chr_ram_ff, cfg_ram_always_ff;

   // ---- result register ----
   logic                  rsp_valid_ff, rsp_valid_in;
   tgt_type               rsp_target_ff;
   logic [MEM_ADDR_W-1:0] rsp_addr_ff;
   logic                  rsp_strobe_ff, rsp_irq_ff, rsp_mirror_ff;

   // ---- translate stage ----
   tgt_type               map_target;
   logic [MEM_ADDR_W-1:0] map_addr;
   logic                  map_strobe;
   logic                  irq_next;
   map_ctl_type           map_ctl;
   irq_ctl_type           irq_ctl;
   logic                  reg_write;
   reg_sel_type           reg_sel;

   // Pipe moves whenever the result slot is free or being drained
   assign advance     = !rsp_valid_ff || rsp_tready;
   assign fire        = in_valid_ff && advance;
   assign req_tready  = !in_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_op_ff    <= op_type'(req_tuser);
         in_addr_ff  <= req_tdata[15:0];
         in_wdata_ff <= req_tdata[23:16];
      end
   end

   // Register decode: address & 0xE001 reduces to {A14, A13, A0} above 0x8000
   assign reg_write = (in_op_ff == OP_CPU_WRITE) && in_addr_ff[15];
   assign reg_sel   = reg_sel_type'({in_addr_ff[14:13], in_addr_ff[0]});

   always_comb begin
      bank_idx_in = bank_idx_ff;
      banks_in    = banks_ff;
      prg_swap_in = prg_swap_ff;
      chr_inv_in  = chr_inv_ff;
      mirror_in   = mirror_ff;
      ram_rd_in   = ram_rd_ff;
      ram_wr_in   = ram_wr_ff;
      if (reg_write) begin
         unique case (reg_sel)
            REG_BANK_SELECT: begin
               bank_idx_in = in_wdata_ff[2:0];
               prg_swap_in = in_wdata_ff[6];
               chr_inv_in  = in_wdata_ff[7];
            end
            REG_BANK_DATA:   banks_in[bank_idx_ff] = in_wdata_ff;
            REG_MIRROR:      mirror_in = in_wdata_ff[0];
            REG_RAM_PROTECT: begin
               // bit 7 chip enable, bit 6 write protect
               ram_rd_in = in_wdata_ff[7];
               ram_wr_in = in_wdata_ff[7] && !in_wdata_ff[6];
            end
            default: ;       // IRQ registers live in the counter block
         endcase
      end
   end

   always_comb begin
      irq_ctl.ppu_access  = in_op_ff[1];
      irq_ctl.a12         = in_addr_ff[12];
      irq_ctl.set_latch   = reg_write && (reg_sel == REG_IRQ_LATCH);
      irq_ctl.latch_val   = in_wdata_ff;
      irq_ctl.set_reload  = reg_write && (reg_sel == REG_IRQ_RELOAD);
      irq_ctl.irq_disable = reg_write && (reg_sel == REG_IRQ_DISABLE);
      irq_ctl.irq_arm     = reg_write && (reg_sel == REG_IRQ_ENABLE);
   end

   // Mapping uses the state before this request; register writes and csr_ writes change it
   always_comb begin
      map_ctl.prg_swap      = prg_swap_ff;
      map_ctl.chr_invert    = chr_inv_ff;
      map_ctl.ram_read_ok   = ram_rd_ff;
      map_ctl.ram_write_ok  = ram_wr_ff;
      map_ctl.prg_size_log2 = cfg_prg_log_ff;
      map_ctl.chr_size_log2 = cfg_chr_log_ff;
      map_ctl.chr_is_ram    = cfg_chr_ram_ff;
      map_ctl.ram_always_on = cfg_ram_always_ff;
   end

   mmc3_map u_map (
      .op           (in_op_ff),
      .address      (in_addr_ff),
      .banks        (banks_ff),
      .ctl          (map_ctl),
      .target       (map_target),
      .mem_addr     (map_addr),
      .write_strobe (map_strobe)
   );

   mmc3_irq u_irq (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .ctl      (irq_ctl),
      .irq_next (irq_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_idx_ff <= 3'd0;
         banks_ff    <= '0;
         prg_swap_ff <= 1'b0;
         chr_inv_ff  <= 1'b0;
         mirror_ff   <= 1'b0;
         ram_rd_ff   <= 1'b0;
         ram_wr_ff   <= 1'b0;
      end else if (fire) begin
         bank_idx_ff <= bank_idx_in;
         banks_ff    <= banks_in;
         prg_swap_ff <= prg_swap_in;
         chr_inv_ff  <= chr_inv_in;
         mirror_ff   <= mirror_in;
         ram_rd_ff   <= ram_rd_in;
         ram_wr_ff   <= ram_wr_in;
      end
   end

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_prg_log_ff    <= SIZE_LOG2_W'(17);
         cfg_chr_log_ff    <= SIZE_LOG2_W'(13);
         cfg_chr_ram_ff    <= 1'b0;
         cfg_ram_always_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (cfg_index_type'(csr_index))
            CFG_PRG_SIZE:   cfg_prg_log_ff    <= csr_data;
            CFG_CHR_SIZE:   cfg_chr_log_ff    <= csr_data;
            CFG_CHR_RAM:    cfg_chr_ram_ff    <= csr_data[0];
            CFG_RAM_ALWAYS: cfg_ram_always_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         rsp_target_ff <= map_target;
         rsp_addr_ff   <= map_addr;
         rsp_strobe_ff <= map_strobe;
         rsp_irq_ff    <= irq_next;
         rsp_mirror_ff <= mirror_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_target_ff;
   assign rsp_tdata  = {rsp_mirror_ff, rsp_irq_ff, rsp_strobe_ff, rsp_addr_ff};

   `MMC3_ASSERT_IMP(a_none_is_quiet, rsp_valid_ff && (rsp_target_ff == TGT_NONE),
      (rsp_addr_ff == '0) && !rsp_strobe_ff, "open-bus response carries address or strobe")
   `MMC3_ASSERT_IMP(a_strobe_target, rsp_valid_ff && rsp_strobe_ff,
      (rsp_target_ff == TGT_WORK_RAM) || (rsp_target_ff == TGT_CHR_RAM),
      "write strobe to a read-only target")
   `MMC3_ASSERT_NXT(a_ack_clears_irq, fire && reg_write && (reg_sel == REG_IRQ_DISABLE),
      !rsp_irq_ff, "IRQ still pending after acknowledge")
   `MMC3_ASSERT_NXT(a_fire_gives_rsp, fire, rsp_valid_ff, "translated request lost")

endmodule

@@ sim/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mmc3_pkg::*;

   // One expected response, field by field
   typedef struct {
      tgt_type                 target;
      logic [MEM_ADDR_W-1:0]   mem_addr;
      logic                    strobe;
      logic                    irq;
      logic                    mirror;
   } mapper_result_type;

   // Mapper predictor plus the queue of responses it has promised
   class scoreboard_type;
      mapper_result_type promised_q[$];
      int              errors;
      // configuration
      logic [4:0]      prg_log2;
      logic [4:0]      chr_log2;
      logic            chr_ram;
      logic            wram_always;
      // mapper state
      logic [2:0]      bank_sel;
      logic [7:0]      banks [NUM_BANKS];
      logic            prg_swap;
      logic            chr_invert;
      logic            mirror_h;
      logic [7:0]      latch;
      logic [7:0]      counter;
      logic            reload_req;
      logic            irq_en;
      logic            prev_a12;
      logic            irq_flag;
      logic            wram_rd;
      logic            wram_wr;

      function new();
         errors      = 0;
         prg_log2    = 5'd17;
         chr_log2    = 5'd13;
         chr_ram     = 1'b0;
         wram_always = 1'b0;
         bank_sel    = '0;
         foreach (banks[i]) banks[i] = '0;
         prg_swap    = 1'b0;
         chr_invert  = 1'b0;
         mirror_h    = 1'b0;
         latch       = '0;
         counter     = '0;
         reload_req  = 1'b0;
         irq_en      = 1'b0;
         prev_a12    = 1'b1;
         irq_flag    = 1'b0;
         wram_rd     = 1'b0;
         wram_wr     = 1'b0;
      endfunction

      function int outstanding();
         return promised_q.size();
      endfunction

      function int clamp_log2(int v, int lo, int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_config(cfg_index_type idx, logic [4:0] v);
         case (idx)
            CFG_PRG_SIZE:   prg_log2    = v;
            CFG_CHR_SIZE:   chr_log2    = v;
            CFG_CHR_RAM:    chr_ram     = v[0];
            CFG_RAM_ALWAYS: wram_always = v[0];
            default: ;
         endcase
      endfunction

      // scanline counter, clocked on a rising A12
      function void clock_counter(logic a12);
         if (a12 && !prev_a12) begin
            if (counter == 8'd0 || reload_req) counter = latch;
            else counter = counter - 8'd1;
            if (counter == 8'd0 && irq_en) irq_flag = 1'b1;
            reload_req = 1'b0;
         end
         prev_a12 = a12;
      endfunction

      function logic [MEM_ADDR_W-1:0] prg_phys(logic [15:0] a);
         int          size;
         int          base;
         logic [15:0] va;
         size = 1 << clamp_log2(prg_log2, 14, PRG_ADDR_BITS);
         va = a;
         // swap mode trades the 0x8000 and 0xC000 windows
         if (prg_swap && !va[13]) va[14] = ~va[14];
         case (va[15:13])
            3'b100:  base = int'(banks[6]) << 13;
            3'b101:  base = int'(banks[7]) << 13;
            3'b110:  base = size - 'h4000;
            default: base = size - 'h2000;
         endcase
         return MEM_ADDR_W'((int'(va[12:0]) | base) & (size - 1));
      endfunction

      function int chr_phys(logic [12:0] a);
         logic [12:0] va;
         int          base;
         va = a;
         if (chr_invert) va[12] = ~va[12];
         case (va[12:10])
            3'b000, 3'b001: base = int'(banks[0] & 8'hFE) << 10;
            3'b010, 3'b011: base = int'(banks[1] & 8'hFE) << 10;
            3'b100:         base = int'(banks[2]) << 10;
            3'b101:         base = int'(banks[3]) << 10;
            3'b110:         base = int'(banks[4]) << 10;
            default:        base = int'(banks[5]) << 10;
         endcase
         if (va[12]) return int'(va[9:0]) | base;
         return int'(va[10:0]) | base;
      endfunction

      function void write_reg(logic [15:0] a, logic [7:0] d);
         reg_sel_type sel;
         sel = reg_sel_type'({a[14], a[13], a[0]});
         case (sel)
            REG_BANK_SELECT: begin
               bank_sel   = d[2:0];
               prg_swap   = d[6];
               chr_invert = d[7];
            end
            REG_BANK_DATA:   banks[bank_sel] = d;
            REG_MIRROR:      mirror_h = d[0];
            REG_RAM_PROTECT: begin
               wram_rd = d[7];
               wram_wr = d[7] & ~d[6];
            end
            REG_IRQ_LATCH:   latch = d;
            REG_IRQ_RELOAD:  reload_req = 1'b1;
            REG_IRQ_DISABLE: begin
               irq_en   = 1'b0;
               irq_flag = 1'b0;
            end
            default:         irq_en = 1'b1;
         endcase
      endfunction

      function void note_request(op_type op, logic [15:0] a, logic [7:0] d);
         mapper_result_type r;
         int           cmask;
         int           ca;
         r.target   = TGT_NONE;
         r.mem_addr = '0;
         r.strobe   = 1'b0;
         if (op == OP_CPU_READ || op == OP_CPU_WRITE) begin
            if (a[15]) begin
               if (op == OP_CPU_READ) begin
                  r.target   = TGT_PRG_ROM;
                  r.mem_addr = prg_phys(a);
               end else begin
                  write_reg(a, d);
                  r.target   = TGT_REGISTER;
                  r.mem_addr = MEM_ADDR_W'(a & 16'hE001);
               end
            end else if (a >= 16'h6000) begin
               if (wram_always || (op == OP_CPU_READ ? wram_rd : wram_wr)) begin
                  r.target   = TGT_WORK_RAM;
                  r.mem_addr = MEM_ADDR_W'(a[12:0]);
                  r.strobe   = (op == OP_CPU_WRITE);
               end
            end
         end else begin
            // only the low 13 bits count on the PPU side
            cmask = (1 << clamp_log2(chr_log2, 10, CHR_ADDR_BITS)) - 1;
            clock_counter(a[12]);
            ca = chr_phys(a[12:0]);
            if (op == OP_PPU_READ) begin
               if (chr_ram) r.target = TGT_CHR_RAM;
               else r.target = TGT_CHR_ROM;
               r.mem_addr = MEM_ADDR_W'(ca & cmask);
            end else if (chr_ram) begin
               r.target   = TGT_CHR_RAM;
               r.mem_addr = MEM_ADDR_W'(ca & 'h1FFF & cmask);
               r.strobe   = 1'b1;
            end
         end
         r.irq    = irq_flag;
         r.mirror = mirror_h;
         promised_q.push_back(r);
      endfunction

      function void check_response(logic [2:0] target, logic [MEM_ADDR_W-1:0] ma,
                                   logic s, logic irq, logic mir);
         mapper_result_type e;
         if (promised_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = promised_q.pop_front();
         if (target !== e.target) begin
            $error("target: expected %0d, got %0d", e.target, target);
            errors++;
         end
         if (ma !== e.mem_addr) begin
            $error("mem_addr: expected 0x%06h, got 0x%06h", e.mem_addr, ma);
            errors++;
         end
         if (s !== e.strobe) begin
            $error("write_strobe: expected %0b, got %0b", e.strobe, s);
            errors++;
         end
         if (irq !== e.irq) begin
            $error("irq_out: expected %0b, got %0b", e.irq, irq);
            errors++;
         end
         if (mir !== e.mirror) begin
            $error("mirror_horizontal: expected %0b, got %0b", e.mirror, mir);
            errors++;
         end
      endfunction
   endclass

   // DUT-facing signals; those the bench drives are known from time zero
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = '0;
   logic [4:0]  csr_data    = '0;

   bit          steady      = 1'b0;   // no idling on either side while set
   bit          ppu_a12     = 1'b1;   // A12 of the last PPU request sent
   scoreboard_type sb;

   bank_switch_mapper_with_scanline_irq dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Response side back-pressure: roughly 18% stall, none during the steady phase
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 18);
   end

   // Monitor: everything is sampled at the edge, before this edge's drive takes effect.
   // Requests are noted ahead of the response check, so the predictor is never behind.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_config(cfg_index_type'(csr_index), csr_data);
         if (req_tvalid && req_tready)
            sb.note_request(op_type'(req_tuser), req_tdata[15:0], req_tdata[23:16]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata[20:0], rsp_tdata[21], rsp_tdata[22],
                              rsp_tdata[23]);
      end
   end

   // One request; idles at random first, holds tvalid high across back-to-back requests
   task automatic send_request(op_type op, logic [15:0] a, logic [7:0] d);
      while (!steady && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {d, a};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   // Sender holds off until every promised response is in, then lets the pipe settle
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (4) @(posedge clock);
   endtask

   // All four registers, only ever called with the mapper idle
   task automatic program_config(logic [4:0] prg, logic [4:0] chr, logic cram, logic always_on);
      cfg_index_type idx [4];
      logic [4:0]    val [4];
      idx = '{CFG_PRG_SIZE, CFG_CHR_SIZE, CFG_CHR_RAM, CFG_RAM_ALWAYS};
      val = '{prg, chr, {4'd0, cram}, {4'd0, always_on}};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly register programming, PRG reads and PPU fetches with A12 toggling,
   // so the counter and the interrupt actually fire; the rest is RAM and noise.
   task automatic random_burst(int n);
      op_type      op;
      logic [15:0] a;
      logic [7:0]  d;
      int          pick;
      repeat (n) begin
         pick = $urandom_range(99);
         a    = 16'($urandom);
         d    = 8'($urandom);
         if (pick < 28) begin
            op    = OP_CPU_WRITE;
            a[15] = 1'b1;
            // short latch values so the count reaches zero often
            if (a[14:13] == 2'b10 && !a[0] && $urandom_range(1)) d = 8'($urandom_range(7));
         end else if (pick < 48) begin
            op    = OP_CPU_READ;
            a[15] = 1'b1;
         end else if (pick < 58) begin
            op        = op_type'($urandom_range(1));
            a[15:13]  = 3'b011;
         end else if (pick < 62) begin
            op    = op_type'($urandom_range(1));
            a[15] = 1'b0;
            if (a[14:13] == 2'b11) a[13] = 1'b0;
         end else begin
            op = op_type'(2 + $urandom_range(1));
            if ($urandom_range(1)) a[15:13] = 3'b000;
            if ($urandom_range(4) < 3) a[12] = ~ppu_a12;
         end
         if (op == OP_PPU_READ || op == OP_PPU_WRITE) ppu_a12 = a[12];
         send_request(op, a, d);
         if ($urandom_range(79) == 0) wait_for_responses();
      end
   endtask

   // Directed walk: open bus, RAM protect, bank switching, fixed banks, swap mode,
   // mirroring, PPU address above the pattern space, CHR ROM write, and one interrupt.
   task automatic directed_requests();
      send_request(OP_CPU_READ,  16'h0000, 8'h00);   // below work RAM
      send_request(OP_CPU_WRITE, 16'h5FFF, 8'hFF);
      send_request(OP_CPU_READ,  16'h6000, 8'h00);   // RAM still disabled
      send_request(OP_CPU_WRITE, 16'hA001, 8'h80);   // enable, writable
      send_request(OP_CPU_WRITE, 16'h7FFF, 8'hFF);
      send_request(OP_CPU_READ,  16'h6000, 8'h00);
      send_request(OP_CPU_WRITE, 16'hA001, 8'hC0);   // write-protected
      send_request(OP_CPU_WRITE, 16'h6001, 8'h00);
      send_request(OP_CPU_WRITE, 16'h8000, 8'h06);
      send_request(OP_CPU_WRITE, 16'h8001, 8'hFF);
      send_request(OP_CPU_WRITE, 16'h8000, 8'h47);   // swap mode, select bank 7
      send_request(OP_CPU_WRITE, 16'h8001, 8'h00);
      send_request(OP_CPU_READ,  16'h8000, 8'h00);
      send_request(OP_CPU_READ,  16'hBFFF, 8'h00);
      send_request(OP_CPU_READ,  16'hC000, 8'h00);
      send_request(OP_CPU_READ,  16'hFFFF, 8'h00);
      send_request(OP_CPU_WRITE, 16'hA000, 8'h01);   // horizontal mirroring
      send_request(OP_CPU_WRITE, 16'hC000, 8'h01);   // latch
      send_request(OP_CPU_WRITE, 16'hC001, 8'h00);   // reload
      send_request(OP_CPU_WRITE, 16'hE001, 8'h00);   // enable
      send_request(OP_PPU_READ,  16'h0000, 8'h00);
      send_request(OP_PPU_READ,  16'h1FFF, 8'h00);   // edge: reload
      send_request(OP_PPU_READ,  16'hE000, 8'h00);   // high bits dropped, A12 low
      send_request(OP_PPU_WRITE, 16'h1000, 8'hA5);   // edge: count hits zero; CHR ROM write
      send_request(OP_CPU_WRITE, 16'hE000, 8'h00);   // disable and acknowledge
      ppu_a12 = 1'b1;
   endtask

   initial begin
      // settings after the default one: range edges, out-of-range values, then random
      logic [4:0] prg_set  [5];
      logic [4:0] chr_set  [5];
      logic       cram_set [5];
      logic       wram_set [5];
      prg_set  = '{5'd14, 5'd21, 5'd0,  5'd31, 5'd0};
      chr_set  = '{5'd10, 5'd18, 5'd31, 5'd0,  5'd0};
      cram_set = '{1'b1,  1'b0,  1'b1,  1'b0,  1'b0};
      wram_set = '{1'b1,  1'b1,  1'b0,  1'b0,  1'b0};
      sb = new();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_config(5'd17, 5'd13, 1'b0, 1'b0);
      directed_requests();
      random_burst(90);
      wait_for_responses();

      for (int p = 0; p < 5; p++) begin
         if (p == 4) begin
            prg_set[p]  = 5'($urandom);
            chr_set[p]  = 5'($urandom);
            cram_set[p] = 1'($urandom);
            wram_set[p] = 1'($urandom);
         end
         program_config(prg_set[p], chr_set[p], cram_set[p], wram_set[p]);
         steady = (p == 1);
         random_burst(100);
         wait_for_responses();
      end
      steady = 1'b0;

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/mmc3_pkg.sv
sv/mmc3_irq.sv
sv/mmc3_map.sv
sv/bank_switch_mapper_with_scanline_irq.sv
sim/testbench.sv
